/* hdl/assert_macros.svh */
// Assertion macros shared by the climate hysteresis controller RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hdl/chc_pkg.sv */
// Types and fixed constants of the climate hysteresis controller.
// Used by every module; depends on nothing.
package chc_pkg;

    // Operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 12;
    localparam logic [CFG_INDEX_W-1:0] REG_FAN_TEMP_ON        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FAN_TEMP_OFF       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FAN_HUM_ON         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FAN_HUM_OFF        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HOT_TEMP           = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SOIL_DRY_LEVEL     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SOIL_OK_LEVEL      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SOIL_CRITICAL_LEVEL = 3'd7;

    // Timing constants in milliseconds
    localparam logic [31:0] RUN_PERIOD_MS = 32'd3000;
    localparam logic [31:0] FAN_MIN_ON_MS = 32'd5000;

    // Light thresholds on the raw ADC scale
    localparam logic [11:0] LIGHT_DARK = 12'd500;
    localparam logic [11:0] LIGHT_OK   = 12'd900;

    // Soil scaling: percent = (4095 - raw) * 100 / 3000 = (4095 - raw) / 30.
    // Divide by 30 as multiply by ceil(2^16 / 30) and shift; exact for 12-bit values.
    localparam logic [11:0] ADC_FULL    = 12'd4095;
    localparam logic [11:0] SOIL_RECIP  = 12'd2185;
    localparam int unsigned SOIL_SHIFT  = 16;
    localparam logic [7:0]  SOIL_MAX    = 8'd100;

    // Colors
    localparam logic [7:0] COLOR_FULL  = 8'd255;
    localparam logic [7:0] COLOR_AMBER = 8'd120;
    localparam logic [7:0] COLOR_DIM   = 8'd80;
    localparam logic [7:0] COLOR_OFF   = 8'd0;

    typedef struct packed {
        logic signed [11:0] fan_temp_on;
        logic signed [11:0] fan_temp_off;
        logic [9:0]         fan_hum_on;
        logic [9:0]         fan_hum_off;
        logic signed [11:0] hot_temp;
        logic [6:0]         soil_dry_level;
        logic [6:0]         soil_ok_level;
        logic [6:0]         soil_critical_level;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        fan_temp_on:         12'sd280,
        fan_temp_off:        12'sd260,
        fan_hum_on:          10'd700,
        fan_hum_off:         10'd600,
        hot_temp:            12'sd300,
        soil_dry_level:      7'd27,
        soil_ok_level:       7'd40,
        soil_critical_level: 7'd20
    };

    typedef struct packed {
        logic               operation;
        logic               enabled;
        logic [31:0]        now_ms;
        logic signed [11:0] temperature;
        logic               temperature_valid;
        logic [9:0]         humidity;
        logic               humidity_valid;
        logic [11:0]        soil_raw;
        logic [11:0]        light_raw;
        logic               fan_is_on;
    } sample_t;

    typedef struct packed {
        logic       fan_request;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       alert;
    } result_t;

    typedef struct packed {
        logic        fan_latch;
        logic        soil_dry_latch;
        logic        dim_latch;
        logic [31:0] last_run_time;
        logic [31:0] fan_min_on_deadline;
    } state_t;

    // Outcome of one sample: whether it answers, the new state and the answer
    typedef struct packed {
        logic    has_result;
        state_t  state_next;
        result_t res;
    } eval_t;

endpackage

/* hdl/chc_sample_if.sv */
// Sample request channel of the climate hysteresis controller.
// Stand-alone; field widths follow chc_pkg but are written out here.
interface chc_sample_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic               enabled;
    logic [31:0]        now_ms;
    logic signed [11:0] temperature;
    logic               temperature_valid;
    logic [9:0]         humidity;
    logic               humidity_valid;
    logic [11:0]        soil_raw;
    logic [11:0]        light_raw;
    logic               fan_is_on;

    modport source (
        output valid, operation, enabled, now_ms, temperature, temperature_valid,
               humidity, humidity_valid, soil_raw, light_raw, fan_is_on,
        input  ready
    );
    modport sink (
        input  valid, operation, enabled, now_ms, temperature, temperature_valid,
               humidity, humidity_valid, soil_raw, light_raw, fan_is_on,
        output ready
    );
endinterface

/* hdl/chc_result_if.sv */
// Result channel of the climate hysteresis controller.
// Stand-alone; carries the fan request, RGB color and alert flag.
interface chc_result_if;
    logic       valid;
    logic       ready;
    logic       fan_request;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       alert;

    modport source (
        output valid, fan_request, red, green, blue, alert,
        input  ready
    );
    modport sink (
        input  valid, fan_request, red, green, blue, alert,
        output ready
    );
endinterface

/* hdl/chc_cfg_if.sv */
// Configuration write channel of the climate hysteresis controller.
// Stand-alone; a register index and write data per request.
interface chc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [11:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* hdl/chc_cfg_regs.sv */
// Configuration register file of the climate hysteresis controller.
// Depends on chc_pkg and chc_cfg_if.
module chc_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    chc_cfg_if.sink       cfg,
    output chc_pkg::cfg_t regs
);

    chc_pkg::cfg_t regs_reg;
    chc_pkg::cfg_t regs_next;
    logic          wr_en;

    // Take every write at once
    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid & cfg.ready;
    assign regs      = regs_reg;

    // Decode the register index and truncate the data to the field width
    always_comb
    begin
        regs_next = regs_reg;
        if (wr_en)
        begin
            case (cfg.index)
                chc_pkg::REG_FAN_TEMP_ON:         regs_next.fan_temp_on = $signed(cfg.data[11:0]);
                chc_pkg::REG_FAN_TEMP_OFF:        regs_next.fan_temp_off = $signed(cfg.data[11:0]);
                chc_pkg::REG_FAN_HUM_ON:          regs_next.fan_hum_on = cfg.data[9:0];
                chc_pkg::REG_FAN_HUM_OFF:         regs_next.fan_hum_off = cfg.data[9:0];
                chc_pkg::REG_HOT_TEMP:            regs_next.hot_temp = $signed(cfg.data[11:0]);
                chc_pkg::REG_SOIL_DRY_LEVEL:      regs_next.soil_dry_level = cfg.data[6:0];
                chc_pkg::REG_SOIL_OK_LEVEL:       regs_next.soil_ok_level = cfg.data[6:0];
                chc_pkg::REG_SOIL_CRITICAL_LEVEL: regs_next.soil_critical_level = cfg.data[6:0];
                default:                          regs_next = regs_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= chc_pkg::CFG_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

/* hdl/chc_eval.sv */
// Single-pass evaluation of one sample against the latches and timers.
// Depends on chc_pkg; purely combinational.
module chc_eval (
    input  chc_pkg::cfg_t    cfg,
    input  chc_pkg::state_t  st,
    input  chc_pkg::sample_t smp,
    output chc_pkg::eval_t   ev
);

    logic        is_clear;
    logic [31:0] elapsed;
    logic        too_soon;
    logic        run;
    logic [11:0] soil_diff;
    logic [23:0] soil_prod;
    logic [7:0]  soil_quot;
    logic [6:0]  soil_pct;
    logic        temp_ok;
    logic        hum_ok;
    logic        fan_set;
    logic        cool;
    logic        dry_air;
    logic        fan_release;
    logic        fan_latch_new;
    logic        soil_latch_new;
    logic        dim_latch_new;
    logic        hot_dry;
    logic        want_fan;
    chc_pkg::result_t res;

    assign is_clear = (smp.operation == chc_pkg::OP_CLEAR);
    assign temp_ok  = smp.temperature_valid;
    assign hum_ok   = smp.humidity_valid;

    // Rate limit: a zero last run time means never run
    assign elapsed  = smp.now_ms - st.last_run_time;
    assign too_soon = (st.last_run_time != 32'd0) && (elapsed < chc_pkg::RUN_PERIOD_MS);
    assign run      = smp.enabled && !too_soon;

    // Scale soil to a percentage by reciprocal multiply, then clamp
    assign soil_diff = chc_pkg::ADC_FULL - smp.soil_raw;
    assign soil_prod = 24'(soil_diff) * 24'(chc_pkg::SOIL_RECIP);
    assign soil_quot = soil_prod[chc_pkg::SOIL_SHIFT +: 8];
    assign soil_pct  = (soil_quot > chc_pkg::SOIL_MAX) ? chc_pkg::SOIL_MAX[6:0] : soil_quot[6:0];

    // Fan latch: release wins over set
    assign fan_set = (temp_ok && ($signed(smp.temperature) >= $signed(cfg.fan_temp_on)))
                  || (hum_ok && (smp.humidity >= cfg.fan_hum_on));
    assign cool    = !temp_ok || ($signed(smp.temperature) <= $signed(cfg.fan_temp_off));
    assign dry_air = !hum_ok || (smp.humidity <= cfg.fan_hum_off);
    assign fan_release   = cool && dry_air && (smp.now_ms >= st.fan_min_on_deadline);
    assign fan_latch_new = fan_release ? 1'b0 : (fan_set | st.fan_latch);

    // Soil and dim latches: clearing wins over setting
    assign soil_latch_new = (soil_pct >= cfg.soil_ok_level) ? 1'b0
                          : ((soil_pct <= cfg.soil_dry_level) | st.soil_dry_latch);
    assign dim_latch_new  = (smp.light_raw >= chc_pkg::LIGHT_OK) ? 1'b0
                          : ((smp.light_raw <= chc_pkg::LIGHT_DARK) | st.dim_latch);

    // Color by priority: hot and critically dry, then dry soil, then dim
    assign hot_dry  = temp_ok && ($signed(smp.temperature) >= $signed(cfg.hot_temp))
                   && (soil_pct <= cfg.soil_critical_level);
    assign want_fan = fan_latch_new | hot_dry;

    always_comb
    begin
        res.fan_request = want_fan;
        res.red         = chc_pkg::COLOR_OFF;
        res.green       = chc_pkg::COLOR_OFF;
        res.blue        = chc_pkg::COLOR_OFF;
        res.alert       = 1'b0;
        if (hot_dry)
        begin
            res.red   = chc_pkg::COLOR_FULL;
            res.alert = 1'b1;
        end
        else if (soil_latch_new)
        begin
            res.red   = chc_pkg::COLOR_FULL;
            res.green = chc_pkg::COLOR_AMBER;
            res.alert = 1'b1;
        end
        else if (dim_latch_new)
        begin
            res.red   = chc_pkg::COLOR_DIM;
            res.green = chc_pkg::COLOR_DIM;
            res.blue  = chc_pkg::COLOR_DIM;
        end
    end

    // Pick the outcome: clear, skipped sample or run
    always_comb
    begin
        ev.has_result = 1'b0;
        ev.state_next = st;
        ev.res        = res;
        if (is_clear)
        begin
            ev.has_result = 1'b1;
            ev.state_next = '0;
            ev.res        = '0;
        end
        else if (run)
        begin
            ev.has_result                     = 1'b1;
            ev.state_next.last_run_time       = smp.now_ms;
            ev.state_next.fan_latch           = fan_latch_new;
            ev.state_next.soil_dry_latch      = soil_latch_new;
            ev.state_next.dim_latch           = dim_latch_new;
            if (want_fan && !smp.fan_is_on)
            begin
                ev.state_next.fan_min_on_deadline = smp.now_ms + chc_pkg::FAN_MIN_ON_MS;
            end
        end
    end

endmodule

/* hdl/climate_hysteresis_controller.sv */
// Climate hysteresis controller, top level.
// Depends on chc_pkg, the chc_*_if interfaces, chc_cfg_regs, chc_eval and assert_macros.svh.
//
// Usage:
//   sample : request channel; each request is a sample step (operation 0) or a
//            clear (operation 1) with timestamp and sensor readings.
//   result : one answer per clear and per sample that runs; disabled samples and
//            samples within 3000 ms of the last run give no answer.
//   cfg    : register writes (index 0..7), always ready; write only while idle.
// Pipeline: a request is captured in the input register at acceptance; its answer
//   is loaded into the result register when the request leaves the input register.
// Throughput: one request per cycle while results are taken. The latches and timers
//   are updated in the same cycle the request moves out of the input register, so
//   the next request already sees them.
// Reset: latches, last run time and fan deadline clear to zero, registers take
//   their defaults, both pipeline registers empty.
// Stall: while a result waits untaken, the input register holds its request and
//   sample ready drops once that register is full; nothing is lost.
module climate_hysteresis_controller (
    input logic          clk,
    input logic          rst_n,
    chc_sample_if.sink   sample,
    chc_result_if.source result,
    chc_cfg_if.sink      cfg
);

    `include "assert_macros.svh"

    chc_pkg::cfg_t    cfg_regs;
    chc_pkg::sample_t smp_in;
    chc_pkg::sample_t smp_reg;
    logic             smp_valid_reg;
    logic             smp_valid_next;
    chc_pkg::state_t  state_reg;
    chc_pkg::state_t  state_next;
    chc_pkg::result_t res_reg;
    logic             res_valid_reg;
    logic             res_valid_next;
    chc_pkg::eval_t   ev;
    logic             in_take;
    logic             advance;
    logic             clear_advance;

    // Configuration registers
    chc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    // Evaluate the request held in the input register
    chc_eval u_eval (
        .cfg (cfg_regs),
        .st  (state_reg),
        .smp (smp_reg),
        .ev  (ev)
    );

    // Pack the incoming request
    always_comb
    begin
        smp_in.operation         = sample.operation;
        smp_in.enabled           = sample.enabled;
        smp_in.now_ms            = sample.now_ms;
        smp_in.temperature       = sample.temperature;
        smp_in.temperature_valid = sample.temperature_valid;
        smp_in.humidity          = sample.humidity;
        smp_in.humidity_valid    = sample.humidity_valid;
        smp_in.soil_raw          = sample.soil_raw;
        smp_in.light_raw         = sample.light_raw;
        smp_in.fan_is_on         = sample.fan_is_on;
    end

    // Advance when the result register is free or draining
    assign advance      = smp_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !smp_valid_reg || advance;
    assign in_take      = sample.valid && sample.ready;

    // Next values of the control state
    always_comb
    begin
        smp_valid_next = smp_valid_reg;
        if (in_take)
        begin
            smp_valid_next = 1'b1;
        end
        else if (advance)
        begin
            smp_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance && ev.has_result)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end

        state_next = advance ? ev.state_next : state_reg;
    end

    // Control registers and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            smp_valid_reg <= smp_valid_next;
            res_valid_reg <= res_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            smp_reg <= smp_in;
        end
        if (advance && ev.has_result)
        begin
            res_reg <= ev.res;
        end
    end

    // Drive the result channel
    assign result.valid       = res_valid_reg;
    assign result.fan_request = res_reg.fan_request;
    assign result.red         = res_reg.red;
    assign result.green       = res_reg.green;
    assign result.blue        = res_reg.blue;
    assign result.alert       = res_reg.alert;

    // Flag a clear request leaving the input register
    assign clear_advance = advance && (smp_reg.operation == chc_pkg::OP_CLEAR);

    // A clear empties the latches and timers and answers all off
    `ASSERT_NEXT(a_clear_state, clear_advance, state_reg == '0)
    `ASSERT_NEXT(a_clear_result, clear_advance, res_valid_reg && (res_reg == '0))
    // A request that gives no answer leaves the state alone
    `ASSERT_NEXT(a_skip_keeps_state, advance && !ev.has_result, state_reg == $past(state_reg))
    // Every alert color is full red
    `ASSERT_IMPL(a_alert_red, res_valid_reg && res_reg.alert, res_reg.red == chc_pkg::COLOR_FULL)

endmodule
